// ===== rtl/core/tcme_pkg.sv =====
// Shared types, constants and codes of the triggered capture min/max envelope block.
package tcme_pkg;

  // Default sizing, handed to the top level parameters
  localparam int RING_DEPTH_DEF  = 16384;
  localparam int MAX_COLUMNS_DEF = 4096;

  // Fixed field widths of the channels
  localparam int SAMPLE_BITS = 16;
  localparam int MODE_BITS   = 3;
  localparam int COLUMN_BITS = 12;
  localparam int OFFSET_BITS = 14;
  localparam int COUNT_BITS  = 15;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 15;
  localparam int LEVEL_BITS  = 15;
  localparam int SPAN_BITS   = 15;
  localparam int WIDTH_BITS  = 13;

  // Smallest visible window
  localparam int MIN_SPAN = 16;

  // Register reset values
  localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = 15'd16384;
  localparam logic [SPAN_BITS-1:0]  SPAN_RESET  = 15'd1024;
  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 13'd512;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_TRIGGER_LEVEL = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TIME_SPAN     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PLOT_WIDTH    = 2'd2;

  // Item modes
  localparam logic [MODE_BITS-1:0] MODE_SAMPLE = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_PAUSE  = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_RESUME = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_ARM    = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_DISARM = 3'd4;
  localparam logic [MODE_BITS-1:0] MODE_COLUMN = 3'd5;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP1,
    ST_PREP2,
    ST_PREP3,
    ST_PREP4,
    ST_MUL,
    ST_LOAD0,
    ST_DIV0,
    ST_LOAD1,
    ST_DIV1,
    ST_BOUNDS,
    ST_ADDR,
    ST_WALK,
    ST_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic push_status;
    logic prep1;
    logic prep2;
    logic prep3;
    logic prep4;
    logic mul;
    logic div_load0;
    logic div_load1;
    logic take_q0;
    logic take_q1;
    logic bounds;
    logic addr;
    logic walk;
    logic set_empty;
    logic push_col;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic early_empty;
    logic num_small;
    logic div_busy;
    logic walk_none;
    logic walk_last;
  } stat_t;

  // One result item
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] col_min;
    logic signed [SAMPLE_BITS-1:0] col_max;
    logic                          column_empty;
    logic                          trigger_fired;
    logic                          paused_flag;
    logic                          armed_flag;
    logic [COUNT_BITS-1:0]         stored_count;
  } result_t;

endpackage

// ===== rtl/core/tcme_if.sv =====
// Channel interfaces: item input, result output and register write.
interface tcme_in_if;
  import tcme_pkg::*;
  logic                          valid;
  logic                          ready;
  logic [MODE_BITS-1:0]          mode;
  logic signed [SAMPLE_BITS-1:0] sample_i;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic [COLUMN_BITS-1:0]        column;
  logic                          select_q;
  logic [OFFSET_BITS-1:0]        view_offset;

  modport source (output valid, mode, sample_i, sample_q, column, select_q, view_offset,
                  input ready);
  modport sink (input valid, mode, sample_i, sample_q, column, select_q, view_offset,
                output ready);
endinterface

interface tcme_out_if;
  import tcme_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] col_min;
  logic signed [SAMPLE_BITS-1:0] col_max;
  logic                          column_empty;
  logic                          trigger_fired;
  logic                          paused_flag;
  logic                          armed_flag;
  logic [COUNT_BITS-1:0]         stored_count;

  modport source (output valid, col_min, col_max, column_empty, trigger_fired, paused_flag,
                  armed_flag, stored_count, input ready);
  modport sink (input valid, col_min, col_max, column_empty, trigger_fired, paused_flag,
                armed_flag, stored_count, output ready);
endinterface

interface tcme_cfg_if;
  import tcme_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/tcme_div.sv =====
// Restoring divider, one quotient bit per cycle.
module tcme_div #(
  parameter int DW = 28,
  parameter int VW = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quotient
);

  localparam int CNT_W = (DW > 1) ? $clog2(DW) : 1;

  logic [VW-1:0]    rem;
  logic [DW-1:0]    quo;
  logic [CNT_W-1:0] cnt;
  logic [VW:0]      rem_sh;
  logic [VW:0]      diff;
  logic             ge;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    rem_sh = {rem, quo[DW-1]};
    ge     = rem_sh >= {1'b0, divisor};
    diff   = rem_sh - {1'b0, divisor};
  end

  // Iterate over all dividend bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= '0;
      quo  <= dividend;
      rem  <= '0;
    end else if (busy) begin
      quo <= {quo[DW-2:0], ge};
      rem <= ge ? diff[VW-1:0] : rem_sh[VW-1:0];
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(DW - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient = quo;

endmodule

// ===== rtl/core/tcme_ctrl.sv =====
// Controller state machine: sequences item handling and column requests.
module tcme_ctrl
  import tcme_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [MODE_BITS-1:0] mode,
  input  logic                 q_space,
  input  stat_t                stat,
  output logic                 in_ready,
  output cmd_t                 cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = in_valid && in_ready;

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance through the column request steps
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && mode == MODE_COLUMN) state_next = ST_PREP1;
      end
      ST_PREP1: state_next = stat.early_empty ? ST_DONE : ST_PREP2;
      ST_PREP2: state_next = ST_PREP3;
      ST_PREP3: state_next = ST_PREP4;
      ST_PREP4: state_next = ST_MUL;
      ST_MUL:   state_next = stat.num_small ? ST_DONE : ST_LOAD0;
      ST_LOAD0: state_next = ST_DIV0;
      ST_DIV0: begin
        if (!stat.div_busy) state_next = ST_LOAD1;
      end
      ST_LOAD1: state_next = ST_DIV1;
      ST_DIV1: begin
        if (!stat.div_busy) state_next = ST_BOUNDS;
      end
      ST_BOUNDS: state_next = stat.walk_none ? ST_DONE : ST_ADDR;
      ST_ADDR:   state_next = ST_WALK;
      ST_WALK: begin
        if (stat.walk_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (q_space) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Drive handshake and datapath commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = q_space;
        if (accept) begin
          cmd.accept      = 1'b1;
          cmd.push_status = (mode != MODE_COLUMN);
        end
      end
      ST_PREP1: begin
        cmd.prep1     = 1'b1;
        cmd.set_empty = stat.early_empty;
      end
      ST_PREP2: cmd.prep2 = 1'b1;
      ST_PREP3: cmd.prep3 = 1'b1;
      ST_PREP4: cmd.prep4 = 1'b1;
      ST_MUL: begin
        cmd.mul       = !stat.num_small;
        cmd.set_empty = stat.num_small;
      end
      ST_LOAD0: cmd.div_load0 = 1'b1;
      ST_DIV0:  cmd.take_q0 = !stat.div_busy;
      ST_LOAD1: cmd.div_load1 = 1'b1;
      ST_DIV1:  cmd.take_q1 = !stat.div_busy;
      ST_BOUNDS: begin
        cmd.bounds    = !stat.walk_none;
        cmd.set_empty = stat.walk_none;
      end
      ST_ADDR: cmd.addr = 1'b1;
      ST_WALK: cmd.walk = 1'b1;
      ST_DONE: cmd.push_col = q_space;
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/tcme_datapath.sv =====
// Datapath: capture state, sample ring, column bounds, divider and min/max walk.
module tcme_datapath
  import tcme_pkg::*;
#(
  parameter int RING_DEPTH  = RING_DEPTH_DEF,
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  input  logic [MODE_BITS-1:0]          mode,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_q,
  input  logic [COLUMN_BITS-1:0]        column,
  input  logic                          select_q,
  input  logic [OFFSET_BITS-1:0]        view_offset,
  input  cmd_t                          cmd,
  output stat_t                         stat,
  output logic                          push,
  output result_t                       result
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int FW = $clog2(RING_DEPTH + 1);
  localparam int CW = $clog2(MAX_COLUMNS + 1);
  localparam int PW = COLUMN_BITS + 1 + FW;
  localparam logic [31:0] DEPTH32 = 32'(RING_DEPTH);
  localparam logic [31:0] MAXC32  = 32'(MAX_COLUMNS);
  localparam logic [31:0] MINS32  = 32'(MIN_SPAN);

  // Configuration registers
  logic [LEVEL_BITS-1:0] trigger_level;
  logic [SPAN_BITS-1:0]  time_span;
  logic [WIDTH_BITS-1:0] plot_width;

  // Capture state
  logic [AW-1:0] write_head, write_head_next;
  logic [FW-1:0] fill_count, fill_count_next;
  logic          is_paused, is_paused_next;
  logic          is_armed, is_armed_next;
  logic          fired;
  logic          mem_we;

  // Column request registers
  logic [COLUMN_BITS-1:0] col_r;
  logic                   sel_r;
  logic [OFFSET_BITS-1:0] off_r;
  logic [FW-1:0]          span_r;
  logic [CW-1:0]          w_r;
  logic [FW-1:0]          max_off;
  logic [FW-1:0]          off_c;
  logic [FW-1:0]          view_end;
  logic [FW-1:0]          num;
  logic [FW-1:0]          view_begin;
  logic [PW-1:0]          prod0;
  logic [FW-1:0]          q0, q1;
  logic [FW-1:0]          s0;
  logic [FW-1:0]          cnt;
  logic [AW-1:0]          rd_addr;
  logic                   rvalid;
  logic                   first;
  logic                   col_empty;
  logic signed [SAMPLE_BITS-1:0] acc_min, acc_max;

  // Ring memory
  logic [2*SAMPLE_BITS-1:0] ring [RING_DEPTH];
  logic [2*SAMPLE_BITS-1:0] rdata;

  // Divider
  logic          div_load;
  logic [PW-1:0] div_dividend;
  logic [PW-1:0] div_quotient;
  logic          div_busy;

  // Trigger compare and request setup values
  logic [SAMPLE_BITS:0]  mag_i, mag_q;
  logic signed [SAMPLE_BITS:0] ext_i, ext_q;
  logic                  over_level;
  logic [31:0]           ts32, span_c, pw32, w_c;
  logic [FW:0]           addr_sum;
  logic signed [SAMPLE_BITS-1:0] rd_val;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_level <= LEVEL_RESET;
      time_span     <= SPAN_RESET;
      plot_width    <= WIDTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TRIGGER_LEVEL: trigger_level <= cfg_data[LEVEL_BITS-1:0];
        CFG_TIME_SPAN:     time_span     <= cfg_data[SPAN_BITS-1:0];
        CFG_PLOT_WIDTH:    plot_width    <= cfg_data[WIDTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Magnitudes against the trigger level
  always_comb begin
    ext_i = {sample_i[SAMPLE_BITS-1], sample_i};
    ext_q = {sample_q[SAMPLE_BITS-1], sample_q};
    mag_i = ext_i[SAMPLE_BITS] ? (SAMPLE_BITS + 1)'(-ext_i) : ext_i;
    mag_q = ext_q[SAMPLE_BITS] ? (SAMPLE_BITS + 1)'(-ext_q) : ext_q;
    over_level = (mag_i > (SAMPLE_BITS + 1)'(trigger_level)) ||
                 (mag_q > (SAMPLE_BITS + 1)'(trigger_level));
  end

  // Decode the item and update capture state
  always_comb begin
    write_head_next = write_head;
    fill_count_next = fill_count;
    is_paused_next  = is_paused;
    is_armed_next   = is_armed;
    fired           = 1'b0;
    mem_we          = 1'b0;
    if (cmd.accept) begin
      unique case (mode)
        MODE_SAMPLE: begin
          if (!is_paused) begin
            if (is_armed && over_level) begin
              is_paused_next = 1'b1;
              fired          = 1'b1;
            end else begin
              mem_we = 1'b1;
              write_head_next = (write_head == AW'(RING_DEPTH - 1)) ? '0 : write_head + 1'b1;
              if (fill_count < FW'(RING_DEPTH)) fill_count_next = fill_count + 1'b1;
            end
          end
        end
        MODE_PAUSE:  is_paused_next = 1'b1;
        MODE_RESUME: begin
          is_paused_next = 1'b0;
          is_armed_next  = 1'b0;
        end
        MODE_ARM: begin
          if (!is_paused) is_armed_next = 1'b1;
        end
        MODE_DISARM: is_armed_next = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_head <= '0;
      fill_count <= '0;
      is_paused  <= 1'b0;
      is_armed   <= 1'b0;
    end else begin
      write_head <= write_head_next;
      fill_count <= fill_count_next;
      is_paused  <= is_paused_next;
      is_armed   <= is_armed_next;
    end
  end

  // Ring write on a stored sample, registered read during the walk
  always_ff @(posedge clk) begin
    if (mem_we) ring[write_head] <= {sample_i, sample_q};
    if (cmd.walk && cnt != '0) rdata <= ring[rd_addr];
  end

  // Clamp span and width when a column request arrives
  always_comb begin
    ts32   = 32'(time_span);
    span_c = (ts32 < MINS32) ? MINS32 : ((ts32 > DEPTH32) ? DEPTH32 : ts32);
    pw32   = 32'(plot_width);
    w_c    = (pw32 > MAXC32) ? MAXC32 : pw32;
    addr_sum = (FW + 1)'(write_head) + (FW + 1)'(s0);
    if (fill_count < FW'(RING_DEPTH)) addr_sum = (FW + 1)'(s0);
    if (32'(addr_sum) >= DEPTH32) addr_sum = addr_sum - (FW + 1)'(RING_DEPTH);
  end

  // Column bounds, one step per state
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      col_r     <= column;
      sel_r     <= select_q;
      off_r     <= view_offset;
      span_r    <= FW'(span_c);
      w_r       <= CW'(w_c);
      col_empty <= 1'b0;
    end
    if (cmd.set_empty) col_empty <= 1'b1;
    if (cmd.prep1) max_off <= (fill_count > span_r) ? fill_count - span_r : '0;
    if (cmd.prep2) off_c <= (32'(off_r) > 32'(max_off)) ? max_off : FW'(off_r);
    if (cmd.prep3) view_end <= fill_count - off_c;
    if (cmd.prep4) begin
      num        <= (span_r < view_end) ? span_r : view_end;
      view_begin <= (span_r < view_end) ? view_end - span_r : '0;
    end
    if (cmd.mul) prod0 <= PW'(col_r) * PW'(num);
    if (cmd.take_q0) q0 <= div_quotient[FW-1:0];
    if (cmd.take_q1) q1 <= div_quotient[FW-1:0];
    if (cmd.bounds) begin
      s0  <= view_begin + q0;
      cnt <= q1 - q0;
    end
    if (cmd.addr) rd_addr <= addr_sum[AW-1:0];
    if (cmd.walk && cnt != '0) begin
      cnt     <= cnt - 1'b1;
      rd_addr <= (rd_addr == AW'(RING_DEPTH - 1)) ? '0 : rd_addr + 1'b1;
    end
  end

  // Divide both column edges by the width on the shared divider
  assign div_load     = cmd.div_load0 || cmd.div_load1;
  assign div_dividend = cmd.div_load1 ? prod0 + PW'(num) : prod0;

  tcme_div #(
    .DW (PW),
    .VW (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .load     (div_load),
    .dividend (div_dividend),
    .divisor  (w_r),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  // Track read data and fold it into the envelope
  assign rd_val = sel_r ? rdata[SAMPLE_BITS-1:0] : rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= 1'b0;
    end else begin
      rvalid <= cmd.walk && cnt != '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.addr) first <= 1'b1;
    if (rvalid) begin
      first <= 1'b0;
      if (first || rd_val < acc_min) acc_min <= rd_val;
      if (first || rd_val > acc_max) acc_max <= rd_val;
    end
  end

  // Status toward the controller
  always_comb begin
    stat.early_empty = (w_r == '0) || (32'(col_r) >= 32'(w_r)) || (fill_count < FW'(2));
    stat.num_small   = num < FW'(2);
    stat.div_busy    = div_busy;
    stat.walk_none   = q1 <= q0;
    stat.walk_last   = cnt == '0;
  end

  // Build the result item
  always_comb begin
    push = cmd.push_status || cmd.push_col;
    result.col_min       = '0;
    result.col_max       = '0;
    result.column_empty  = 1'b0;
    result.trigger_fired = fired;
    result.paused_flag   = is_paused_next;
    result.armed_flag    = is_armed_next;
    result.stored_count  = COUNT_BITS'(fill_count_next);
    if (cmd.push_col) begin
      result.column_empty = col_empty;
      if (!col_empty) begin
        result.col_min = acc_min;
        result.col_max = acc_max;
      end
    end
  end

endmodule

// ===== rtl/core/tcme_outq.sv =====
// Two-entry result queue between the datapath and the output channel.
module tcme_outq
  import tcme_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    space,
  tcme_out_if.source results
);

  result_t     entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        pop;
  result_t     head;

  assign pop   = results.valid && results.ready;
  assign space = count != 2'd2;
  assign head  = entry[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

  // Present the oldest request result
  assign results.valid         = count != 2'd0;
  assign results.col_min       = head.col_min;
  assign results.col_max       = head.col_max;
  assign results.column_empty  = head.column_empty;
  assign results.trigger_fired = head.trigger_fired;
  assign results.paused_flag   = head.paused_flag;
  assign results.armed_flag    = head.armed_flag;
  assign results.stored_count  = head.stored_count;

endmodule

// ===== rtl/core/triggered_capture_minmax_envelope_top.sv =====
// Top level of the triggered capture min/max envelope block.
// Sample, pause, resume, arm and disarm items are accepted in consecutive cycles while
// the two-entry result queue has room, so a stalled result does not stop capture until
// a second one waits. A column request holds the input until its result can be queued;
// the restoring divider of width PW = 13 + bits of the fill count (28 with the default
// ring of 16384), one quotient bit per cycle and used twice for the column edges, and
// the single ring read port, one sample per cycle, set how long it holds. Requests whose
// column is empty finish after the bound check that finds it empty. The ring needs no
// clearing after reset; register writes are taken at any time and the block expects
// them only while it is idle.
module triggered_capture_minmax_envelope_top
  import tcme_pkg::*;
#(
  parameter int RING_DEPTH  = RING_DEPTH_DEF,
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  tcme_in_if.sink    samples,
  tcme_cfg_if.sink   cfg,
  tcme_out_if.source results
);

  cmd_t    cmd;
  stat_t   stat;
  logic    q_space;
  logic    push;
  result_t push_data;

  // Accept register writes at once
  assign cfg.ready = 1'b1;

  tcme_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .mode     (samples.mode),
    .q_space  (q_space),
    .stat     (stat),
    .in_ready (samples.ready),
    .cmd      (cmd)
  );

  tcme_datapath #(
    .RING_DEPTH  (RING_DEPTH),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .mode        (samples.mode),
    .sample_i    (samples.sample_i),
    .sample_q    (samples.sample_q),
    .column      (samples.column),
    .select_q    (samples.select_q),
    .view_offset (samples.view_offset),
    .cmd         (cmd),
    .stat        (stat),
    .push        (push),
    .result      (push_data)
  );

  tcme_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .space     (q_space),
    .results   (results)
  );

endmodule

// ===== rtl/core/tcme_checker.sv =====
// Port checker for the envelope block and its bind to the top level.
module tcme_checker
  import tcme_pkg::*;
(
  input logic                          clk,
  input logic                          rst,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic signed [SAMPLE_BITS-1:0] col_min,
  input logic signed [SAMPLE_BITS-1:0] col_max,
  input logic                          column_empty,
  input logic                          trigger_fired,
  input logic                          paused_flag,
  input logic                          armed_flag,
  input logic [COUNT_BITS-1:0]         stored_count
);

  // A stalled result stays and holds its payload
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(col_min) && $stable(col_max) &&
      $stable(column_empty) && $stable(trigger_fired) && $stable(stored_count))
    else $error("stalled result changed");

  // No result right after reset
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // A fired trigger leaves capture paused and armed on a sample result
  assert property (@(posedge clk) disable iff (rst)
    res_valid && trigger_fired |-> paused_flag && armed_flag && !column_empty)
    else $error("inconsistent trigger result");

  // Empty columns report zero bounds
  assert property (@(posedge clk) disable iff (rst)
    res_valid && column_empty |-> col_min == '0 && col_max == '0)
    else $error("empty column with nonzero bounds");

endmodule

bind triggered_capture_minmax_envelope_top tcme_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (results.valid),
  .res_ready     (results.ready),
  .col_min       (results.col_min),
  .col_max       (results.col_max),
  .column_empty  (results.column_empty),
  .trigger_fired (results.trigger_fired),
  .paused_flag   (results.paused_flag),
  .armed_flag    (results.armed_flag),
  .stored_count  (results.stored_count)
);

// ===== test/envelope_checker.sv =====
`timescale 1ns / 1ps
// Envelope checker: mirrors capture state and registers, predicts every result and compares it.
module envelope_checker
  import tcme_pkg::*;
#(
  parameter int RING_DEPTH  = RING_DEPTH_DEF,
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic clk,
  input  logic rst,
  tcme_in_if   samples,
  tcme_cfg_if  cfg,
  tcme_out_if  results,
  output int   fail_count,
  output int   pending_count
);

  localparam int PRINT_CAP = 100;

  // Captured I/Q history and capture control
  logic signed [SAMPLE_BITS-1:0] ring_i [RING_DEPTH];
  logic signed [SAMPLE_BITS-1:0] ring_q [RING_DEPTH];
  int unsigned head;
  int unsigned fill;
  bit          paused;
  bit          armed;

  // Register copies
  int unsigned level;
  int unsigned span_reg;
  int unsigned width_reg;

  result_t expected_results[$];
  int      mismatches;
  int      results_seen;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_CAP)
      $display("%0t: result %0d: %s got %0d expected %0d", $realtime, results_seen, what,
               got, want);
    mismatches++;
  endtask

  // Min and max of one pixel column; returns 1 when the column covers no samples
  function automatic bit scan_column(input int unsigned col, input bit sel,
                                     input int unsigned off,
                                     output logic signed [SAMPLE_BITS-1:0] lo,
                                     output logic signed [SAMPLE_BITS-1:0] hi);
    int unsigned w, sp, max_off, view_end, num, view_begin, s0, s1, oldest;
    logic signed [SAMPLE_BITS-1:0] v;
    lo = '0;
    hi = '0;
    w = (width_reg > MAX_COLUMNS) ? MAX_COLUMNS : width_reg;
    sp = span_reg;
    if (sp < MIN_SPAN) sp = MIN_SPAN;
    if (sp > RING_DEPTH) sp = RING_DEPTH;
    if (w == 0 || col >= w || fill < 2) return 1'b1;
    // Keep the view inside the stored samples
    max_off = (fill > sp) ? fill - sp : 0;
    if (off > max_off) off = max_off;
    view_end = fill - off;
    num = (sp < view_end) ? sp : view_end;
    if (num < 2) return 1'b1;
    view_begin = view_end - num;
    s0 = view_begin + (col * num) / w;
    s1 = view_begin + ((col + 1) * num) / w;
    if (s1 > view_end) s1 = view_end;
    if (s1 <= s0) return 1'b1;
    // Walk the column from the oldest valid slot
    oldest = (fill < RING_DEPTH) ? 0 : head;
    for (int unsigned k = s0; k < s1; k++) begin
      v = sel ? ring_q[(oldest + k) % RING_DEPTH] : ring_i[(oldest + k) % RING_DEPTH];
      if (k == s0 || v < lo) lo = v;
      if (k == s0 || v > hi) hi = v;
    end
    return 1'b0;
  endfunction

  // Advance the capture state by one request and form its result
  function automatic result_t apply_item(input logic [MODE_BITS-1:0] mode,
                                         input logic signed [SAMPLE_BITS-1:0] si,
                                         input logic signed [SAMPLE_BITS-1:0] sq,
                                         input logic [COLUMN_BITS-1:0] col,
                                         input logic sel,
                                         input logic [OFFSET_BITS-1:0] off);
    result_t r;
    int mi, mq;
    logic signed [SAMPLE_BITS-1:0] lo, hi;
    r = '0;
    case (mode)
      MODE_SAMPLE: begin
        mi = si;
        mq = sq;
        if (mi < 0) mi = -mi;
        if (mq < 0) mq = -mq;
        if (!paused && armed && (mi > int'(level) || mq > int'(level))) begin
          paused = 1'b1;
          r.trigger_fired = 1'b1;
        end else if (!paused) begin
          ring_i[head] = si;
          ring_q[head] = sq;
          head = (head + 1) % RING_DEPTH;
          if (fill < RING_DEPTH) fill++;
        end
      end
      MODE_PAUSE:  paused = 1'b1;
      MODE_RESUME: begin
        paused = 1'b0;
        armed = 1'b0;
      end
      MODE_ARM:    if (!paused) armed = 1'b1;
      MODE_DISARM: armed = 1'b0;
      MODE_COLUMN: begin
        r.column_empty = scan_column(col, sel, off, lo, hi);
        r.col_min = lo;
        r.col_max = hi;
      end
      default: ;
    endcase
    r.paused_flag = paused;
    r.armed_flag = armed;
    r.stored_count = COUNT_BITS'(fill);
    return r;
  endfunction

  // Track register writes, predict accepted requests, compare delivered results
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      head = 0;
      fill = 0;
      paused = 1'b0;
      armed = 1'b0;
      level = LEVEL_RESET;
      span_reg = SPAN_RESET;
      width_reg = WIDTH_RESET;
      expected_results.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_TRIGGER_LEVEL: level = cfg.data;
          CFG_TIME_SPAN:     span_reg = cfg.data;
          CFG_PLOT_WIDTH:    width_reg = cfg.data[WIDTH_BITS-1:0];
          default: ;
        endcase
      end
      if (samples.valid && samples.ready)
        expected_results.push_back(apply_item(samples.mode, samples.sample_i, samples.sample_q,
                                              samples.column, samples.select_q,
                                              samples.view_offset));
      if (results.valid && results.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, stored_count", results.stored_count, -1);
        end else begin
          want = expected_results.pop_front();
          if (results.col_min !== want.col_min)
            report_mismatch("col_min", results.col_min, want.col_min);
          if (results.col_max !== want.col_max)
            report_mismatch("col_max", results.col_max, want.col_max);
          if (results.column_empty !== want.column_empty)
            report_mismatch("column_empty", results.column_empty, want.column_empty);
          if (results.trigger_fired !== want.trigger_fired)
            report_mismatch("trigger_fired", results.trigger_fired, want.trigger_fired);
          if (results.paused_flag !== want.paused_flag)
            report_mismatch("paused_flag", results.paused_flag, want.paused_flag);
          if (results.armed_flag !== want.armed_flag)
            report_mismatch("armed_flag", results.armed_flag, want.armed_flag);
          if (results.stored_count !== want.stored_count)
            report_mismatch("stored_count", results.stored_count, want.stored_count);
        end
      end
    end
    pending_count <= expected_results.size();
  end

endmodule

// ===== test/triggered_capture_minmax_envelope_top_test.sv =====
`timescale 1ns / 1ps
// Testbench top: drives requests and register writes into the envelope block, gives the verdict.
module triggered_capture_minmax_envelope_top_test;
  import tcme_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending_count;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_asks;
  int   hold_served;
  int   hold_left;
  int   cur_level;
  int   cur_width;

  tcme_in_if  samples ();
  tcme_cfg_if cfg ();
  tcme_out_if results ();

  triggered_capture_minmax_envelope_top dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .cfg     (cfg),
    .results (results)
  );

  envelope_checker #(
    .RING_DEPTH  (RING_DEPTH_DEF),
    .MAX_COLUMNS (MAX_COLUMNS_DEF)
  ) env_check (
    .clk           (clk),
    .rst           (rst),
    .samples       (samples),
    .cfg           (cfg),
    .results       (results),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // 50 MHz clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Hard stop for a hung block
  initial begin
    #40_000_000;
    $display("FAIL triggered_capture_minmax_envelope_top");
    $finish;
  end

  // Result drain: random stalls, plus a long hold whenever one is asked for
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      results.ready <= 1'b0;
    end else if (hold_served != hold_asks) begin
      hold_served <= hold_asks;
      hold_left <= HOLD_CYCLES;
      results.ready <= 1'b0;
    end else begin
      results.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one request after a random idle gap; return at the cycle it is taken
  task automatic send_req(input logic [MODE_BITS-1:0] mode,
                          input logic signed [SAMPLE_BITS-1:0] si,
                          input logic signed [SAMPLE_BITS-1:0] sq,
                          input logic [COLUMN_BITS-1:0] col,
                          input logic sel,
                          input logic [OFFSET_BITS-1:0] off);
    while ($urandom_range(99) < send_idle_pct) begin
      samples.valid <= 1'b0;
      @(posedge clk);
    end
    samples.valid <= 1'b1;
    samples.mode <= mode;
    samples.sample_i <= si;
    samples.sample_q <= sq;
    samples.column <= col;
    samples.select_q <= sel;
    samples.view_offset <= off;
    do @(posedge clk); while (!samples.ready);
  endtask

  task automatic send_sample(input int si, input int sq);
    send_req(MODE_SAMPLE, SAMPLE_BITS'(si), SAMPLE_BITS'(sq), COLUMN_BITS'($urandom()),
             1'($urandom()), OFFSET_BITS'($urandom()));
  endtask

  task automatic send_ctrl(input logic [MODE_BITS-1:0] mode);
    send_req(mode, SAMPLE_BITS'($urandom()), SAMPLE_BITS'($urandom()),
             COLUMN_BITS'($urandom()), 1'($urandom()), OFFSET_BITS'($urandom()));
  endtask

  task automatic send_column(input int col, input bit sel, input int off);
    send_req(MODE_COLUMN, SAMPLE_BITS'($urandom()), SAMPLE_BITS'($urandom()),
             COLUMN_BITS'(col), sel, OFFSET_BITS'(off));
  endtask

  // Hold the input quiet until every predicted result has been delivered
  task automatic drain();
    samples.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register with the block idle
  task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx, input int value);
    drain();
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= CFG_DATA_BITS'(value);
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == CFG_TRIGGER_LEVEL) cur_level = value & 32'h7FFF;
    else if (idx == CFG_PLOT_WIDTH) cur_width = value & 32'h1FFF;
  endtask

  // Sample value: full range, under the level, at its edges, or near zero
  function automatic int rand_value();
    int mag;
    case ($urandom_range(3))
      0: return int'(SAMPLE_BITS'($urandom()));
      1: begin
        mag = $urandom_range(cur_level);
        return $urandom_range(1) ? -mag : mag;
      end
      2: begin
        case ($urandom_range(5))
          0: return -32768;
          1: return 32767;
          2: return cur_level;
          3: return -cur_level;
          4: return cur_level + 1;
          default: return -cur_level - 1;
        endcase
      end
      default: return int'($urandom_range(31)) - 16;
    endcase
  endfunction

  // Column mostly inside the plot, sometimes anywhere
  function automatic int rand_column();
    int cols;
    cols = (cur_width > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : cur_width;
    if (cols > 0 && $urandom_range(9) < 8) return $urandom_range(cols - 1);
    return $urandom_range(4095);
  endfunction

  function automatic int rand_offset();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return $urandom_range(63);
      5, 6, 7: return $urandom_range(4095);
      default: return $urandom_range(16383);
    endcase
  endfunction

  // Mixed traffic: mostly samples and column requests, with trigger control and noise
  task automatic run_random(input int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 50) send_sample(rand_value(), rand_value());
      else if (pick < 75) send_column(rand_column(), 1'($urandom()), rand_offset());
      else if (pick < 82) send_ctrl(MODE_ARM);
      else if (pick < 90) send_ctrl(MODE_RESUME);
      else if (pick < 93) send_ctrl(MODE_PAUSE);
      else if (pick < 96) send_ctrl(MODE_DISARM);
      else send_ctrl(MODE_BITS'($urandom_range(7)));
    end
  endtask

  initial begin : stimulus
    rst <= 1'b1;
    samples.valid <= 1'b0;
    samples.mode <= MODE_SAMPLE;
    samples.sample_i <= '0;
    samples.sample_q <= '0;
    samples.column <= '0;
    samples.select_q <= 1'b0;
    samples.view_offset <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= CFG_TRIGGER_LEVEL;
    cfg.data <= '0;
    hold_asks <= 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cur_level = LEVEL_RESET;
    cur_width = WIDTH_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty ring, single sample, sparse window, clamped offset
    send_column(0, 1'b0, 0);
    send_sample(32767, -32768);
    send_column(0, 1'b0, 0);
    send_sample(-32768, 32767);
    send_sample(0, 0);
    send_sample(1, -1);
    send_column(0, 1'b1, 16383);
    send_column(127, 1'b1, 16383);
    send_column(511, 1'b0, 0);
    send_column(512, 1'b0, 0);
    send_column(4095, 1'b1, 0);
    // Trigger: at the level keeps the sample, most negative value fires
    send_ctrl(MODE_ARM);
    send_sample(100, -100);
    send_sample(16384, -16384);
    send_sample(-32768, 0);
    send_ctrl(MODE_PAUSE);
    send_ctrl(MODE_ARM);
    send_ctrl(MODE_DISARM);
    send_ctrl(MODE_RESUME);
    send_ctrl(MODE_ARM);
    send_sample(0, 16385);
    send_ctrl(MODE_RESUME);
    send_ctrl(MODE_BITS'(6));
    send_ctrl(MODE_BITS'(7));

    // Register extremes
    write_register(CFG_TRIGGER_LEVEL, 0);
    send_ctrl(MODE_ARM);
    send_sample(0, 0);
    send_sample(0, -1);
    send_ctrl(MODE_RESUME);
    write_register(CFG_TRIGGER_LEVEL, 32767);
    send_ctrl(MODE_ARM);
    send_sample(32767, -32767);
    send_sample(5, -32768);
    send_ctrl(MODE_RESUME);
    write_register(CFG_TIME_SPAN, 0);
    write_register(CFG_PLOT_WIDTH, 0);
    send_column(0, 1'b0, 0);
    send_column(4095, 1'b1, 16383);
    write_register(CFG_PLOT_WIDTH, 8191);
    write_register(CFG_TIME_SPAN, 32767);
    send_column(0, 1'b0, 0);
    send_column(3, 1'b1, 2);
    send_column(4095, 1'b0, 0);
    write_register(CFG_SPARE, 32767);

    // Short window, few columns, ring still filling
    write_register(CFG_TRIGGER_LEVEL, 8000);
    write_register(CFG_TIME_SPAN, 64);
    write_register(CFG_PLOT_WIDTH, 16);
    run_random(400);

    // Burst of samples with capture running
    send_ctrl(MODE_RESUME);
    repeat (60) send_sample(rand_value(), rand_value());

    // Whole ring in one or two columns
    write_register(CFG_TIME_SPAN, 16384);
    write_register(CFG_PLOT_WIDTH, 1);
    send_column(0, 1'b0, 0);
    send_column(0, 1'b1, 16383);
    write_register(CFG_PLOT_WIDTH, 2);
    send_column(1, 1'b1, 100);
    send_column(0, 1'b0, 0);

    // Sender idles most cycles
    write_register(CFG_TRIGGER_LEVEL, 1000);
    write_register(CFG_PLOT_WIDTH, 4096);
    send_idle_pct = 86;
    run_random(400);

    // Receiver stalls most cycles, uneven column split
    write_register(CFG_TRIGGER_LEVEL, 20000);
    write_register(CFG_TIME_SPAN, 300);
    write_register(CFG_PLOT_WIDTH, 7);
    send_idle_pct = 0;
    recv_stall_pct = 86;
    run_random(400);

    // Light idling on both sides, saturated span and width
    write_register(CFG_TRIGGER_LEVEL, 0);
    write_register(CFG_TIME_SPAN, 32767);
    write_register(CFG_PLOT_WIDTH, 8191);
    send_idle_pct = 12;
    recv_stall_pct = 12;
    run_random(400);

    // Back-pressure: long receiver hold while requests keep coming, a full drain, then idling traffic
    write_register(CFG_TRIGGER_LEVEL, 30000);
    write_register(CFG_TIME_SPAN, 16);
    write_register(CFG_PLOT_WIDTH, 3);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_asks <= hold_asks + 1;
    run_random(150);
    drain();
    send_idle_pct = 30;
    run_random(100);

    drain();
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS triggered_capture_minmax_envelope_top");
    end else begin
      $display("FAIL triggered_capture_minmax_envelope_top");
    end
    $finish;
  end

endmodule
